FILE: rtl/prr_pkg.sv
// Shared types, codes and defaults for the polyphase rational resampler.
`timescale 1ns / 1ps

package prr_pkg;

    localparam int DEF_MAX_TAPS      = 4096;
    localparam int DEF_HISTORY_DEPTH = 64;
    localparam int DEF_SAMPLE_BITS   = 16;

    localparam int MAX_OUT     = 64;
    localparam int FACTOR_W    = 11;
    localparam int TAPCNT_W    = 13;
    localparam int PHASE_W     = 11;
    localparam int COEFF_IDX_W = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FACTOR_W-1:0] RST_INTERP = 11'd160;
    localparam logic [FACTOR_W-1:0] RST_DECIM  = 11'd441;
    localparam logic [TAPCNT_W-1:0] RST_TAPS   = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_PUSH    = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT,
        ST_SKIP,
        ST_WRAP
    } state_t;

    typedef struct packed {
        logic clear;
        logic term_vld;
    } mac_ctrl_t;

endpackage

FILE: rtl/prr_ram.sv
// Simple dual-port synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module prr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/prr_mac.sv
// Multiply-accumulate pipeline with round-half-up and saturation of the sum.
`timescale 1ns / 1ps

module prr_mac #(
    parameter int SAMPLE_BITS   = prr_pkg::DEF_SAMPLE_BITS,
    parameter int HISTORY_DEPTH = prr_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prr_pkg::mac_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] coeff,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          busy,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import prr_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int AW = PW + $clog2(HISTORY_DEPTH) + 1;
    localparam int RW = AW - (SAMPLE_BITS - 1);
    localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (SAMPLE_BITS - 2));
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic signed [PW-1:0] prod_reg;
    logic                 prod_vld_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] rnd_sum;
    logic signed [AW-1:0] rnd_shift;
    logic signed [RW-1:0] scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.term_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.term_vld)
        begin
            prod_reg <= coeff * sample;
        end
        acc_reg <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + AW'(prod_reg);
        end
    end

    assign busy = prod_vld_reg;

    always_comb
    begin
        rnd_sum   = acc_reg + HALF;
        rnd_shift = rnd_sum >>> (SAMPLE_BITS - 1);
        scaled    = RW'(rnd_shift);
        if (scaled > SAT_HI)
        begin
            result = SAMPLE_BITS'(SAT_HI);
        end
        else if (scaled < SAT_LO)
        begin
            result = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            result = SAMPLE_BITS'(scaled);
        end
    end

endmodule

FILE: rtl/polyphase_rational_resampler_unit.sv
// Top level: L/M polyphase FIR resampler, sequencer around coefficient and history RAMs.
// Load, restart and unused kinds finish in IDLE. A push writes history, then per output runs
// CHECK, ISSUE, DRAIN and EMIT (EMIT holds while the output stalls), ending in WRAP, or goes
// from CHECK to WRAP with no output; terms per output = min(samples held, ceil((taps - phase)
// / L)) <= HISTORY_DEPTH. Outputs beyond 64 per sample are skipped. One multiplier, one term
// per cycle. Reset sets L/M/taps to 160/441/4096, clears phase and history fill count.
`timescale 1ns / 1ps

module polyphase_rational_resampler_unit #(
    parameter int MAX_TAPS      = prr_pkg::DEF_MAX_TAPS,
    parameter int HISTORY_DEPTH = prr_pkg::DEF_HISTORY_DEPTH,
    parameter int SAMPLE_BITS   = prr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [prr_pkg::COEFF_IDX_W-1:0]   coeff_index,
    input  logic signed [SAMPLE_BITS-1:0]     coeff_value,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    output logic                              last
);
    import prr_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int KW = ((TW > FACTOR_W) ? TW : FACTOR_W) + 1;
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int JW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = $clog2(MAX_OUT);
    localparam int PW = PHASE_W + 1;

    state_t state_reg, state_next;

    logic [FACTOR_W-1:0] interp_reg, decim_reg;
    logic [TAPCNT_W-1:0] taps_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [JW-1:0]      j_reg, j_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [HW-1:0]      rdptr_reg, rdptr_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [HW-1:0]      wp_reg, wp_next;
    logic [HW-1:0]      newest_reg, newest_next;
    logic [JW-1:0]      fill_reg, fill_next;
    logic               rd_vld_reg;
    logic               out_vld_reg, out_vld_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic               out_last_reg;

    logic [FACTOR_W-1:0] l_eff, m_eff;
    logic [TW-1:0]       taps_eff;
    logic [PW-1:0]       p_plus_m;
    logic                more_out;
    logic                term_ok;
    logic                out_free;
    logic                out_load;
    logic                cnt_full;
    logic                in_accept;
    logic                issue;
    logic                hist_we;
    logic                coeff_we;
    logic                clear_acc;

    logic signed [SAMPLE_BITS-1:0] coeff_rd, hist_rd, mac_result;
    logic       mac_busy;
    mac_ctrl_t  mac_ctrl;

    assign l_eff     = (interp_reg == '0) ? FACTOR_W'(1) : interp_reg;
    assign m_eff     = (decim_reg == '0) ? FACTOR_W'(1) : decim_reg;
    assign taps_eff  = (32'(taps_reg) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_reg);
    assign p_plus_m  = p_reg + PW'(m_eff);
    assign more_out  = p_plus_m < PW'(l_eff);
    assign term_ok   = (j_reg < fill_reg) && (k_reg < KW'(taps_eff));
    assign out_free  = !out_vld_reg || !out_stall;
    assign cnt_full  = cnt_reg == CW'(MAX_OUT - 1);
    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && kind == KIND_PUSH)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (p_reg < PW'(l_eff)) ? ST_ISSUE : ST_WRAP;
            end
            ST_ISSUE:
            begin
                if (!term_ok)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (!more_out)
                    begin
                        state_next = ST_WRAP;
                    end
                    else if (cnt_full)
                    begin
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SKIP:
            begin
                if (!more_out)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        phase_next  = phase_reg;
        p_next      = p_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        rdptr_next  = rdptr_reg;
        cnt_next    = cnt_reg;
        wp_next     = wp_reg;
        newest_next = newest_reg;
        fill_next   = fill_reg;
        issue       = 1'b0;
        hist_we     = 1'b0;
        coeff_we    = 1'b0;
        clear_acc   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (kind)
                        KIND_LOAD:
                        begin
                            coeff_we = 32'(coeff_index) < MAX_TAPS;
                        end
                        KIND_PUSH:
                        begin
                            hist_we     = 1'b1;
                            newest_next = wp_reg;
                            wp_next     = (wp_reg == HW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                            if (fill_reg < JW'(HISTORY_DEPTH))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            p_next   = {1'b0, phase_reg};
                            cnt_next = '0;
                        end
                        KIND_RESTART:
                        begin
                            fill_next  = '0;
                            phase_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (p_reg < PW'(l_eff))
                begin
                    clear_acc  = 1'b1;
                    j_next     = '0;
                    k_next     = KW'(p_reg);
                    rdptr_next = newest_reg;
                end
            end
            ST_ISSUE:
            begin
                if (term_ok)
                begin
                    issue      = 1'b1;
                    j_next     = j_reg + 1'b1;
                    k_next     = k_reg + KW'(l_eff);
                    rdptr_next = (rdptr_reg == '0) ? HW'(HISTORY_DEPTH - 1) : rdptr_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    p_next   = p_plus_m;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SKIP:
            begin
                p_next = p_plus_m;
            end
            ST_WRAP:
            begin
                phase_next = p_reg[PHASE_W-1:0] - l_eff;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            interp_reg  <= RST_INTERP;
            decim_reg   <= RST_DECIM;
            taps_reg    <= RST_TAPS;
            phase_reg   <= '0;
            p_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rdptr_reg   <= '0;
            cnt_reg     <= '0;
            wp_reg      <= '0;
            newest_reg  <= '0;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            p_reg       <= p_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            rdptr_reg   <= rdptr_next;
            cnt_reg     <= cnt_next;
            wp_reg      <= wp_next;
            newest_reg  <= newest_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= issue;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INTERP: interp_reg <= cfg_data[FACTOR_W-1:0];
                    REG_DECIM:  decim_reg  <= cfg_data[FACTOR_W-1:0];
                    REG_TAPS:   taps_reg   <= cfg_data[TAPCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
            out_last_reg <= !more_out || cnt_full;
        end
    end

    assign out_valid  = out_vld_reg;
    assign sample_out = out_data_reg;
    assign last       = out_last_reg;

    prr_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (AW'(coeff_index)),
        .wdata (coeff_value),
        .re    (issue),
        .raddr (k_reg[AW-1:0]),
        .rdata (coeff_rd)
    );

    prr_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (issue),
        .raddr (rdptr_reg),
        .rdata (hist_rd)
    );

    assign mac_ctrl.clear    = clear_acc;
    assign mac_ctrl.term_vld = rd_vld_reg;

    prr_mac #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coeff  (coeff_rd),
        .sample (hist_rd),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // accumulator is only cleared with the product pipe empty
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctrl.clear |-> (!rd_vld_reg && !mac_busy))
        else $error("accumulator cleared with terms in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= JW'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> out_valid)
        else $error("emitted result not presented");

    a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && kind == KIND_PUSH) |=>
        (state_reg == ST_CHECK && p_reg == {1'b0, $past(phase_reg)}))
        else $error("push did not start from the stored phase");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (!more_out || cnt_full)) |=>
        (state_reg == ST_WRAP || state_reg == ST_SKIP))
        else $error("final result flagged while outputs remain");

endmodule
